// ----- rtl/pip_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the even-odd point-in-polygon block.
// No dependencies; every other file of the block imports this package.
package pip_pkg;

    // Field widths of the request and result channels.
    localparam int DATA_W  = 32;
    localparam int VERT_W  = 2 * DATA_W;
    localparam int CNT_W   = 7;

    // Default capacity of the vertex store.
    localparam int MAX_VERTICES_DEF = 64;

    // Request commands.
    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_APPEND = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;

    // Result status codes.
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    // One vertex as it sits in the store.
    typedef struct packed {
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;
    } t_vertex;

    // One edge handed from the sequencer to the crossing unit.
    typedef struct packed {
        logic    valid;
        logic    last;
        t_vertex v1;
        t_vertex v2;
    } t_edge_req;

    // Verdict of the crossing unit for one edge.
    typedef struct packed {
        logic valid;
        logic last;
        logic hit;
    } t_edge_res;

endpackage

// ----- rtl/pip_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces for requests and results.
// Depends on pip_pkg for the field widths.
interface pip_in_if;
    import pip_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [1:0]               cmd;
    logic signed [DATA_W-1:0] vertex_x;
    logic signed [DATA_W-1:0] vertex_y;
    logic signed [DATA_W-1:0] point_x;
    logic signed [DATA_W-1:0] point_y;

    modport source (output valid, cmd, vertex_x, vertex_y, point_x, point_y, input ready);
    modport sink (input valid, cmd, vertex_x, vertex_y, point_x, point_y, output ready);
endinterface

interface pip_out_if;
    import pip_pkg::*;

    logic             valid;
    logic             ready;
    logic             inside_res;
    logic [CNT_W-1:0] crossings;
    logic [CNT_W-1:0] vertices_held;
    logic             status;

    modport source (output valid, inside_res, crossings, vertices_held, status, input ready);
    modport sink (input valid, inside_res, crossings, vertices_held, status, output ready);
endinterface

// ----- rtl/pip_vmem.sv -----
`timescale 1ns / 1ps
// Vertex store: one write port and one read port, registered read data.
// Depends on pip_pkg for the vertex width.
module pip_vmem #(
    parameter int DEPTH = pip_pkg::MAX_VERTICES_DEF,
    parameter int AW    = $clog2(pip_pkg::MAX_VERTICES_DEF)
) (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [AW-1:0]             i_waddr,
    input  logic [pip_pkg::VERT_W-1:0] i_wdata,
    input  logic                      i_re,
    input  logic [AW-1:0]             i_raddr,
    output logic [pip_pkg::VERT_W-1:0] o_rdata
);
    import pip_pkg::*;

    logic [VERT_W-1:0] r_mem [DEPTH];
    logic [VERT_W-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port with registered read data.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/pip_edge.sv -----
`timescale 1ns / 1ps
// Crossing unit: decides per edge whether the rightward ray from the point
// crosses it. Three register stages: differences, products, compare.
// Depends on pip_pkg for the edge request and result types.
module pip_edge (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  pip_pkg::t_edge_req               i_edge,
    input  logic signed [pip_pkg::DATA_W-1:0] i_px,
    input  logic signed [pip_pkg::DATA_W-1:0] i_py,
    output pip_pkg::t_edge_res               o_res
);
    import pip_pkg::*;

    localparam int DW = DATA_W + 1;
    localparam int PW = 2 * DW;

    // Stage one: straddle test, orientation and differences.
    logic                     gt1;
    logic                     gt2;
    logic                     low1;
    logic signed [DATA_W-1:0] xa;
    logic signed [DATA_W-1:0] ya;
    logic signed [DATA_W-1:0] xb;
    logic signed [DATA_W-1:0] yb;
    logic signed [DW-1:0]     n1_dpx;
    logic signed [DW-1:0]     n1_dy;
    logic signed [DW-1:0]     n1_dpy;
    logic signed [DW-1:0]     n1_dx;

    logic                 r1_valid;
    logic                 r1_last;
    logic                 r1_str;
    logic signed [DW-1:0] r1_dpx;
    logic signed [DW-1:0] r1_dy;
    logic signed [DW-1:0] r1_dpy;
    logic signed [DW-1:0] r1_dx;

    always_comb begin
        gt1  = i_edge.v1.y > i_py;
        gt2  = i_edge.v2.y > i_py;
        low1 = i_edge.v1.y < i_edge.v2.y;
        // Orient the edge so that it runs upward from a to b.
        if (low1) begin
            xa = i_edge.v1.x;
            ya = i_edge.v1.y;
            xb = i_edge.v2.x;
            yb = i_edge.v2.y;
        end else begin
            xa = i_edge.v2.x;
            ya = i_edge.v2.y;
            xb = i_edge.v1.x;
            yb = i_edge.v1.y;
        end
        n1_dpx = {i_px[DATA_W-1], i_px} - {xa[DATA_W-1], xa};
        n1_dy  = {yb[DATA_W-1], yb} - {ya[DATA_W-1], ya};
        n1_dpy = {i_py[DATA_W-1], i_py} - {ya[DATA_W-1], ya};
        n1_dx  = {xb[DATA_W-1], xb} - {xa[DATA_W-1], xa};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else begin
            r1_valid <= i_edge.valid;
        end
        r1_last <= i_edge.last;
        r1_str  <= gt1 != gt2;
        r1_dpx  <= n1_dpx;
        r1_dy   <= n1_dy;
        r1_dpy  <= n1_dpy;
        r1_dx   <= n1_dx;
    end

    // Stage two: the two cross products, exact on full width.
    logic signed [PW-1:0] n2_lhs;
    logic signed [PW-1:0] n2_rhs;
    logic                 r2_valid;
    logic                 r2_last;
    logic                 r2_str;
    logic signed [PW-1:0] r2_lhs;
    logic signed [PW-1:0] r2_rhs;

    assign n2_lhs = r1_dpx * r1_dy;
    assign n2_rhs = r1_dpy * r1_dx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else begin
            r2_valid <= r1_valid;
        end
        r2_last <= r1_last;
        r2_str  <= r1_str;
        r2_lhs  <= n2_lhs;
        r2_rhs  <= n2_rhs;
    end

    // Stage three: crossing lies strictly right of the point.
    t_edge_res r3_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_res.valid <= 1'b0;
        end else begin
            r3_res.valid <= r2_valid;
        end
        r3_res.last <= r2_last;
        r3_res.hit  <= r2_str && (r2_lhs < r2_rhs);
    end

    assign o_res = r3_res;

endmodule

// ----- rtl/point_in_polygon_even_odd.sv -----
`timescale 1ns / 1ps
// Even-odd point-in-polygon block.
// A request on i_req carries a command: clear the polygon, append one vertex
// (x, y in signed Q16.16), or query a point. Every request yields exactly one
// result on o_res with the inside flag, the crossing count, the vertex count
// after the request and a status bit that flags an append to a full store.
// Clear and append are answered from the output register on the cycle after
// the request is accepted. A query with N stored vertices walks the vertex
// memory one entry per cycle, then passes the edges through the three-stage
// crossing unit; its result goes to the output register after the last edge
// verdict is in. An empty polygon is answered like a clear.
// One request is worked on at a time; a new request is taken when the block
// is idle and the output register is empty or being emptied in that cycle.
// When the receiver stalls, the result waits in the output register.
// Reset empties the polygon and the output register; the vertex memory is
// not cleared, since only entries below the vertex count are ever read.
// Depends on pip_pkg, pip_if, pip_vmem and pip_edge.
module point_in_polygon_even_odd #(
    parameter int MAX_VERTICES = pip_pkg::MAX_VERTICES_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    pip_in_if.sink    i_req,
    pip_out_if.source o_res
);
    import pip_pkg::*;

    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int AW = $clog2(MAX_VERTICES);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_WALK  = 4'b0010,
        S_DRAIN = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    t_state                   r_state;
    logic [CW-1:0]            r_count;
    logic [CW-1:0]            r_n;
    logic [CW-1:0]            r_issue;
    logic [CW-1:0]            r_cross;
    logic signed [DATA_W-1:0] r_px;
    logic signed [DATA_W-1:0] r_py;
    logic                     r_ret_valid;
    logic                     r_ret_close;
    logic                     r_ret_first;
    t_vertex                  r_first;
    t_vertex                  r_prev;

    logic             r_out_valid;
    logic             r_out_inside;
    logic [CNT_W-1:0] r_out_cross;
    logic [CNT_W-1:0] r_out_held;
    logic             r_out_status;

    logic              in_ready;
    logic              in_acc;
    logic              out_free;
    logic              full;
    logic              mem_we;
    logic              mem_re;
    logic [VERT_W-1:0] mem_rdata;
    t_vertex           wr_vertex;
    t_vertex           cur;
    t_edge_req         edge_req;
    t_edge_res         edge_res;
    logic [CW-1:0]     n_count;
    logic [CW+CNT_W-1:0] held_ext;
    logic [CW+CNT_W-1:0] cross_ext;

    // Handshake and store status.
    assign out_free = !r_out_valid || o_res.ready;
    assign in_ready = (r_state == S_IDLE) && out_free;
    assign in_acc   = i_req.valid && in_ready;
    assign full     = r_count == CW'(MAX_VERTICES);

    // Vertex memory: appends write at the fill count, queries read in order.
    assign wr_vertex.x = i_req.vertex_x;
    assign wr_vertex.y = i_req.vertex_y;
    assign mem_we = in_acc && (i_req.cmd == CMD_APPEND) && !full;
    assign mem_re = (r_state == S_WALK) && (r_issue != r_n);

    pip_vmem #(
        .DEPTH (MAX_VERTICES),
        .AW    (AW)
    ) u_vmem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (wr_vertex),
        .i_re    (mem_re),
        .i_raddr (r_issue[AW-1:0]),
        .o_rdata (mem_rdata)
    );

    // Returning vertex; the closing step reuses the first vertex.
    always_comb begin
        cur            = r_ret_close ? r_first : t_vertex'(mem_rdata);
        edge_req.valid = r_ret_valid && !r_ret_first;
        edge_req.last  = r_ret_close;
        edge_req.v1    = r_prev;
        edge_req.v2    = cur;
    end

    pip_edge u_edge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_edge  (edge_req),
        .i_px    (r_px),
        .i_py    (r_py),
        .o_res   (edge_res)
    );

    // Vertex count after the accepted request.
    always_comb begin
        n_count = r_count;
        case (i_req.cmd)
            CMD_CLEAR:  n_count = '0;
            CMD_APPEND: n_count = full ? r_count : r_count + CW'(1);
            default:    n_count = r_count;
        endcase
    end

    assign held_ext  = {{CNT_W{1'b0}}, (r_state == S_IDLE) ? n_count : r_count};
    assign cross_ext = {{CNT_W{1'b0}}, r_cross};

    // Sequencer: store control and the edge walk.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_ret_valid <= 1'b0;
        end else begin
            r_ret_valid <= (r_state == S_WALK);
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_count <= n_count;
                        if ((i_req.cmd == CMD_QUERY) && (r_count != '0)) begin
                            r_state <= S_WALK;
                        end
                    end
                end
                S_WALK: begin
                    if (r_issue == r_n) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (edge_res.valid && edge_res.last) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Walk bookkeeping and crossing count.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_px    <= i_req.point_x;
            r_py    <= i_req.point_y;
            r_n     <= r_count;
            r_issue <= '0;
            r_cross <= '0;
        end else begin
            if (r_state == S_WALK) begin
                r_issue <= r_issue + CW'(1);
            end
            if (edge_res.valid && edge_res.hit) begin
                r_cross <= r_cross + CW'(1);
            end
        end
        r_ret_close <= r_issue == r_n;
        r_ret_first <= r_issue == '0;
        if (r_ret_valid) begin
            r_prev <= cur;
            if (r_ret_first) begin
                r_first <= cur;
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc && !((i_req.cmd == CMD_QUERY) && (r_count != '0))) begin
            r_out_valid  <= 1'b1;
            r_out_inside <= 1'b0;
            r_out_cross  <= '0;
            r_out_held   <= held_ext[CNT_W-1:0];
            r_out_status <= ((i_req.cmd == CMD_APPEND) && full) ? STATUS_FULL : STATUS_OK;
        end else if ((r_state == S_DONE) && out_free) begin
            r_out_valid  <= 1'b1;
            r_out_inside <= r_cross[0];
            r_out_cross  <= cross_ext[CNT_W-1:0];
            r_out_held   <= held_ext[CNT_W-1:0];
            r_out_status <= STATUS_OK;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign i_req.ready         = in_ready;
    assign o_res.valid         = r_out_valid;
    assign o_res.inside_res    = r_out_inside;
    assign o_res.crossings     = r_out_cross;
    assign o_res.vertices_held = r_out_held;
    assign o_res.status        = r_out_status;

    // The fill count never passes the store depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_VERTICES))
        else $error("vertex count beyond store depth");

    // An append to a full store leaves the count alone.
    a_full_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (i_req.cmd == CMD_APPEND) && full |=> r_count == $past(r_count))
        else $error("append to full store changed the count");

    // A query on a non-empty polygon starts the walk.
    a_walk_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (i_req.cmd == CMD_QUERY) && (r_count != '0) |=> r_state == S_WALK)
        else $error("query did not start the edge walk");

    // Edge verdicts only arrive while a query is in flight.
    a_edge_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        edge_res.valid |-> (r_state == S_WALK) || (r_state == S_DRAIN))
        else $error("edge verdict outside a query");

    // The crossing count never exceeds the number of edges walked.
    a_cross_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> r_cross <= r_n)
        else $error("more crossings than edges");

endmodule

// ----- verif/point_in_polygon_even_odd_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the even-odd point-in-polygon block.
// Depends on pip_pkg, pip_if and point_in_polygon_even_odd from the rtl folder.
module point_in_polygon_even_odd_tb;
    import pip_pkg::*;

    localparam int MAX_VERTICES    = MAX_VERTICES_DEF;
    localparam int RANDOM_REQUESTS = 460;
    localparam int CALM_TAIL       = 80;
    localparam int DRAIN_CYCLES    = MAX_VERTICES + 16;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int MAX_PRINTED     = 40;

    // Command code that the block must treat as a no-op.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7FFF_FFFF;

    // Ways of drawing a coordinate for vertices and query points.
    typedef enum int {COORD_GRID, COORD_FINE, COORD_EDGE, COORD_FULL} t_coord_style;

    typedef struct packed {
        logic             in_poly;
        logic [CNT_W-1:0] crossings;
        logic [CNT_W-1:0] held;
        logic             status;
    } t_answer;

    // One row of the directed table; rows with reps above one draw grid coordinates.
    typedef struct packed {
        logic [1:0]               cmd;
        logic signed [DATA_W-1:0] vx;
        logic signed [DATA_W-1:0] vy;
        logic signed [DATA_W-1:0] px;
        logic signed [DATA_W-1:0] py;
        logic [7:0]               reps;
        logic                     typed;
        t_answer                  ans;
    } t_stim_row;

    localparam t_answer NO_ANSWER = '0;
    localparam int DIRECTED_ROWS = 22;

    t_stim_row directed [DIRECTED_ROWS] = '{
        '{CMD_QUERY,  0, 0, 0, 0, 1, 1'b1, '{1'b0, 7'd0, 7'd0, STATUS_OK}},
        '{CMD_UNUSED, 0, 0, 0, 0, 1, 1'b1, '{1'b0, 7'd0, 7'd0, STATUS_OK}},
        '{CMD_APPEND, Q_MIN, Q_MIN, 0, 0, 1, 1'b1, '{1'b0, 7'd0, 7'd1, STATUS_OK}},
        '{CMD_QUERY,  0, 0, 0, 0, 1, 1'b1, '{1'b0, 7'd0, 7'd1, STATUS_OK}},
        '{CMD_APPEND, Q_MAX, Q_MIN, 0, 0, 1, 1'b1, '{1'b0, 7'd0, 7'd2, STATUS_OK}},
        '{CMD_QUERY,  0, 0, 0, Q_MIN, 1, 1'b1, '{1'b0, 7'd0, 7'd2, STATUS_OK}},
        '{CMD_APPEND, Q_MAX, Q_MAX, 0, 0, 1, 1'b1, '{1'b0, 7'd0, 7'd3, STATUS_OK}},
        '{CMD_QUERY,  0, 0, 0, 0, 1, 1'b0, NO_ANSWER},
        '{CMD_APPEND, Q_MIN, Q_MAX, 0, 0, 1, 1'b1, '{1'b0, 7'd0, 7'd4, STATUS_OK}},
        '{CMD_QUERY,  0, 0, 0, 0, 1, 1'b0, NO_ANSWER},
        '{CMD_QUERY,  0, 0, Q_MIN, 0, 1, 1'b0, NO_ANSWER},
        '{CMD_QUERY,  0, 0, Q_MAX, Q_MAX, 1, 1'b0, NO_ANSWER},
        '{CMD_QUERY,  0, 0, Q_MIN, Q_MIN, 1, 1'b0, NO_ANSWER},
        '{CMD_QUERY,  0, 0, 0, Q_MIN, 1, 1'b0, NO_ANSWER},
        '{CMD_QUERY,  0, 0, -1, 1, 1, 1'b0, NO_ANSWER},
        '{CMD_UNUSED, 0, 0, 0, 0, 1, 1'b1, '{1'b0, 7'd0, 7'd4, STATUS_OK}},
        '{CMD_CLEAR,  0, 0, 0, 0, 1, 1'b1, '{1'b0, 7'd0, 7'd0, STATUS_OK}},
        '{CMD_QUERY,  0, 0, Q_MAX, Q_MAX, 1, 1'b1, '{1'b0, 7'd0, 7'd0, STATUS_OK}},
        '{CMD_APPEND, 0, 0, 0, 0, 8'(MAX_VERTICES), 1'b0, NO_ANSWER},
        '{CMD_APPEND, Q_MAX, Q_MAX, 0, 0, 1, 1'b1, '{1'b0, 7'd0, 7'd64, STATUS_FULL}},
        '{CMD_QUERY,  0, 0, 0, 0, 8, 1'b0, NO_ANSWER},
        '{CMD_CLEAR,  0, 0, 0, 0, 1, 1'b1, '{1'b0, 7'd0, 7'd0, STATUS_OK}}
    };

    logic i_clk;
    logic i_rst_n;

    pip_in_if  req_bus ();
    pip_out_if res_bus ();

    point_in_polygon_even_odd #(
        .MAX_VERTICES(MAX_VERTICES)
    ) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_bus),
        .o_res  (res_bus)
    );

    // Predicted polygon, kept in step with every accepted request.
    logic signed [DATA_W-1:0] poly_x [MAX_VERTICES];
    logic signed [DATA_W-1:0] poly_y [MAX_VERTICES];
    int poly_count = 0;

    t_answer answers_due [$];
    int      errors = 0;
    int      requests_sent = 0;
    int      calm_from = 32'h7FFF_FFFF;
    bit      calm = 1'b0;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    task automatic flag_mismatch(string msg);
        errors++;
        if (errors <= MAX_PRINTED) begin
            $display("MISMATCH at %0t ns: %s", $time, msg);
        end
    endtask

    // Applies one request to the predicted polygon and returns the answer it earns.
    function automatic t_answer polygon_answer(logic [1:0] cmd,
                                               logic signed [DATA_W-1:0] vx, vy, px, py);
        t_answer ans;
        int hits;
        int idx;
        int nxt;
        logic signed [DATA_W-1:0] xa, ya, xb, yb;
        logic signed [2*DATA_W+1:0] lhs, rhs;
        ans = '0;
        hits = 0;
        case (cmd)
            CMD_CLEAR: begin
                poly_count = 0;
            end
            CMD_APPEND: begin
                if (poly_count < MAX_VERTICES) begin
                    poly_x[poly_count] = vx;
                    poly_y[poly_count] = vy;
                    poly_count++;
                end else begin
                    ans.status = STATUS_FULL;
                end
            end
            CMD_QUERY: begin
                for (idx = 0; idx < poly_count; idx++) begin
                    nxt = (idx + 1 == poly_count) ? 0 : idx + 1;
                    // Only edges that straddle the ray's y can be crossed.
                    if ((poly_y[idx] > py) != (poly_y[nxt] > py)) begin
                        if (poly_y[idx] < poly_y[nxt]) begin
                            xa = poly_x[idx];
                            ya = poly_y[idx];
                            xb = poly_x[nxt];
                            yb = poly_y[nxt];
                        end else begin
                            xa = poly_x[nxt];
                            ya = poly_y[nxt];
                            xb = poly_x[idx];
                            yb = poly_y[idx];
                        end
                        // Crossing x right of px, multiplied through by the positive dy.
                        lhs = (px - xa) * (yb - ya);
                        rhs = (py - ya) * (xb - xa);
                        if (lhs < rhs) begin
                            hits++;
                        end
                    end
                end
                ans.crossings = CNT_W'(hits);
                ans.in_poly = hits[0];
            end
            default: begin
            end
        endcase
        ans.held = CNT_W'(poly_count);
        return ans;
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_coord(t_coord_style style);
        case (style)
            COORD_GRID: return (int'($urandom_range(0, 16)) - 8) * 65536;
            COORD_FINE: return int'($urandom_range(0, 1 << 20)) - (1 << 19);
            COORD_EDGE: begin
                case ($urandom_range(0, 4))
                    0: return Q_MIN;
                    1: return Q_MAX;
                    2: return 0;
                    3: return -1;
                    default: return 1;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    // Drives one request after an optional idle burst and records its answer once taken.
    task automatic issue_request(logic [1:0] cmd, logic signed [DATA_W-1:0] vx, vy, px, py,
                                 logic typed, t_answer typed_ans);
        int gap;
        t_answer predicted;
        gap = (!calm && $urandom_range(0, 5) == 0) ? $urandom_range(1, 7) : 0;
        if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_bus.valid    <= 1'b1;
        req_bus.cmd      <= cmd;
        req_bus.vertex_x <= vx;
        req_bus.vertex_y <= vy;
        req_bus.point_x  <= px;
        req_bus.point_y  <= py;
        do @(posedge i_clk); while (req_bus.ready !== 1'b1);
        predicted = polygon_answer(cmd, vx, vy, px, py);
        answers_due.push_back(typed ? typed_ans : predicted);
        requests_sent++;
        calm = (requests_sent >= calm_from);
    endtask

    // Query point near the polygon, often on the y or the corner of a stored vertex.
    task automatic issue_query(t_coord_style style);
        logic signed [DATA_W-1:0] px, py;
        int k;
        px = pick_coord(($urandom_range(0, 7) == 0) ? COORD_FULL : style);
        py = pick_coord(($urandom_range(0, 7) == 0) ? COORD_FULL : style);
        if (poly_count > 0 && $urandom_range(0, 2) == 0) begin
            k = $urandom_range(0, poly_count - 1);
            py = poly_y[k];
            if ($urandom_range(0, 1) == 0) begin
                px = poly_x[k];
            end
        end
        issue_request(CMD_QUERY, $urandom, $urandom, px, py, 1'b0, NO_ANSWER);
    endtask

    // Holds requests back until the block has answered everything outstanding.
    task automatic wait_for_answers();
        req_bus.valid <= 1'b0;
        do @(posedge i_clk); while (answers_due.size() != 0);
    endtask

    // Request side: reset, directed table, then random polygons and queries.
    initial begin : request_source
        t_coord_style style;
        int shape;
        int size;
        int pick;
        int stop_at;
        logic [1:0] noise_cmd;
        req_bus.valid    <= 1'b0;
        req_bus.cmd      <= CMD_CLEAR;
        req_bus.vertex_x <= '0;
        req_bus.vertex_y <= '0;
        req_bus.point_x  <= '0;
        req_bus.point_y  <= '0;
        i_rst_n          <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[r]) begin
            if (directed[r].reps == 1) begin
                issue_request(directed[r].cmd, directed[r].vx, directed[r].vy,
                              directed[r].px, directed[r].py, directed[r].typed,
                              directed[r].ans);
            end else begin
                repeat (directed[r].reps) begin
                    if (directed[r].cmd == CMD_QUERY) begin
                        issue_query(COORD_GRID);
                    end else begin
                        issue_request(directed[r].cmd, pick_coord(COORD_GRID),
                                      pick_coord(COORD_GRID), $urandom, $urandom,
                                      1'b0, NO_ANSWER);
                    end
                end
            end
        end
        wait_for_answers();

        stop_at = requests_sent + RANDOM_REQUESTS;
        calm_from = stop_at - CALM_TAIL;
        while (requests_sent < stop_at) begin
            shape = $urandom_range(0, 19);
            if (shape < 2) begin
                // Noise: unrelated commands with fully random fields.
                repeat ($urandom_range(1, 6)) begin
                    noise_cmd = ($urandom_range(0, 29) == 0) ? CMD_UNUSED
                                                             : 2'($urandom_range(0, 2));
                    issue_request(noise_cmd, $urandom, $urandom, $urandom, $urandom,
                                  1'b0, NO_ANSWER);
                end
            end else begin
                pick = $urandom_range(0, 9);
                if (pick < 5) begin
                    style = COORD_GRID;
                end else if (pick < 7) begin
                    style = COORD_FINE;
                end else if (pick < 8) begin
                    style = COORD_EDGE;
                end else begin
                    style = COORD_FULL;
                end
                pick = $urandom_range(0, 19);
                if (pick == 0) begin
                    size = $urandom_range(MAX_VERTICES - 4, MAX_VERTICES + 6);
                    wait_for_answers();
                end else if (pick < 3) begin
                    size = $urandom_range(0, 2);
                end else begin
                    size = $urandom_range(3, 10);
                end
                // Now and then the clear is left out and vertices pile onto the old polygon.
                if ($urandom_range(0, 7) != 0) begin
                    issue_request(CMD_CLEAR, $urandom, $urandom, $urandom, $urandom,
                                  1'b0, NO_ANSWER);
                end
                repeat (size) begin
                    issue_request(CMD_APPEND, pick_coord(style), pick_coord(style),
                                  $urandom, $urandom, 1'b0, NO_ANSWER);
                end
                repeat ($urandom_range(1, 6)) begin
                    issue_query(style);
                end
            end
        end

        wait_for_answers();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Result side: random stall bursts and a field-by-field check of every result.
    initial begin : result_sink
        t_answer want;
        int stall_left;
        stall_left = 0;
        res_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && res_bus.valid && res_bus.ready) begin
                if (answers_due.size() == 0) begin
                    flag_mismatch("result arrived with no request outstanding");
                end else begin
                    want = answers_due.pop_front();
                    if (res_bus.inside_res !== want.in_poly) begin
                        flag_mismatch($sformatf("inside_res got %0b want %0b",
                                                res_bus.inside_res, want.in_poly));
                    end
                    if (res_bus.crossings !== want.crossings) begin
                        flag_mismatch($sformatf("crossings got %0d want %0d",
                                                res_bus.crossings, want.crossings));
                    end
                    if (res_bus.vertices_held !== want.held) begin
                        flag_mismatch($sformatf("vertices_held got %0d want %0d",
                                                res_bus.vertices_held, want.held));
                    end
                    if (res_bus.status !== want.status) begin
                        flag_mismatch($sformatf("status got %0b want %0b",
                                                res_bus.status, want.status));
                    end
                end
            end
            if (stall_left > 0) begin
                res_bus.ready <= 1'b0;
                stall_left--;
            end else if (!calm && i_rst_n && $urandom_range(0, 7) == 0) begin
                res_bus.ready <= 1'b0;
                stall_left = $urandom_range(0, 6);
            end else begin
                res_bus.ready <= 1'b1;
            end
        end
    end

    // Ends the run when neither channel has moved for too long.
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((req_bus.valid && req_bus.ready) || (res_bus.valid && res_bus.ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("Watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

endmodule
